[rtl/gnf_pkg.sv]
package gnf_pkg;

    // Register indexes on the configuration channel
    localparam logic [7:0] CFG_SEED      = 8'd0;
    localparam logic [7:0] CFG_OCTAVES   = 8'd1;
    localparam logic [7:0] CFG_BASE_FREQ = 8'd2;
    localparam logic [7:0] CFG_LACUNAR   = 8'd3;
    localparam logic [7:0] CFG_GAIN      = 8'd4;

    // Corner hash multipliers: one per axis, one for the seed, two for the mix
    localparam logic [31:0] H_MUL_X    = 32'h9E3779B1;
    localparam logic [31:0] H_MUL_Y    = 32'h85EBCA77;
    localparam logic [31:0] H_MUL_Z    = 32'hC2B2AE3D;
    localparam logic [31:0] H_MUL_W    = 32'h27D4EB2F;
    localparam logic [31:0] H_MUL_SEED = 32'h165667B1;
    localparam logic [31:0] H_MIX_A    = 32'h85EBCA6B;
    localparam logic [31:0] H_MIX_B    = 32'hC2B2AE35;

    localparam logic [17:0] AMP_ONE  = 18'h10000;
    localparam logic [23:0] FREQ_MAX = 24'hFFFFFF;
    localparam logic [17:0] AMP_MAX  = 18'h3FFFF;

    // Work for one octave of one point
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic             zero;
        logic [17:0]      amp;
        logic [23:0]      freq;
        logic [3:0][31:0] coord;
    } t_job;

    // Side information that travels with an octave
    typedef struct packed {
        logic        first;
        logic        last;
        logic        zero;
        logic [17:0] amp;
    } t_tag;

    // One finished octave
    typedef struct packed {
        logic               valid;
        t_tag               tag;
        logic signed [23:0] value;
    } t_oct;

endpackage

[rtl/gnf_octave.sv]
module gnf_octave (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic [31:0]   i_seed,
    input  gnf_pkg::t_job i_job,
    output gnf_pkg::t_oct o_oct
);

    // Dot product of a hashed gradient with a corner distance vector
    function automatic logic signed [23:0] corner_dot(input logic [4:0] idx,
                                                      input logic [3:0][17:0] d);
        logic signed [23:0] acc;
        logic [1:0]         p;
        acc = '0;
        p   = 2'd0;
        for (int k = 0; k < 4; k++) begin
            if (2'(k) != idx[4:3]) begin
                if (idx[2'd2 - p])
                    acc = acc - 24'($signed(d[k]));
                else
                    acc = acc + 24'($signed(d[k]));
                p = p + 2'd1;
            end
        end
        return acc;
    endfunction

    // Linear blend a + (((b - a) * w) >>> 16)
    function automatic logic signed [23:0] lerp(input logic signed [23:0] a,
                                                input logic signed [23:0] b,
                                                input logic signed [23:0] w);
        logic signed [24:0] diff;
        logic signed [48:0] prod;
        diff = 25'(b) - 25'(a);
        prod = 49'(diff) * 49'(w);
        return a + prod[39:16];
    endfunction

    localparam logic [3:0][31:0] AXIS_MUL = {gnf_pkg::H_MUL_W, gnf_pkg::H_MUL_Z,
                                             gnf_pkg::H_MUL_Y, gnf_pkg::H_MUL_X};

    // Stage 1: scale by frequency
    logic                      r1_v;
    gnf_pkg::t_tag             r1_tag;
    logic signed [56:0]        r1_prod [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (i_adv) r1_v <= i_job.valid;
    end
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_tag <= '{i_job.first, i_job.last, i_job.zero, i_job.amp};
            for (int k = 0; k < 4; k++)
                r1_prod[k] <= 57'($signed(i_job.coord[k])) * 57'($signed({1'b0, i_job.freq}));
        end
    end

    // Stage 2: saturate, split into lattice integer and fraction
    logic                r2_v;
    gnf_pkg::t_tag       r2_tag;
    logic [15:0]         r2_base [4];
    logic [15:0]         r2_frac [4];
    logic signed [40:0]  sh [4];
    logic [31:0]         sc [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            sh[k] = r1_prod[k][56:16];
            if (sh[k] > 41'sd2147483647)       sc[k] = 32'h7FFFFFFF;
            else if (sh[k] < -41'sd2147483648) sc[k] = 32'h80000000;
            else                               sc[k] = sh[k][31:0];
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (i_adv) r2_v <= r1_v;
    end
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_tag <= r1_tag;
            for (int k = 0; k < 4; k++) begin
                r2_base[k] <= sc[k][31:16];
                r2_frac[k] <= sc[k][15:0];
            end
        end
    end

    // Stage 3: per-axis hash terms, seed term, t squared
    logic           r3_v;
    gnf_pkg::t_tag  r3_tag;
    logic [31:0]    r3_p [4];
    logic [31:0]    r3_seedh;
    logic [15:0]    r3_t2 [4];
    logic [15:0]    r3_frac [4];
    logic [31:0]    sq [4];

    always_comb begin
        for (int k = 0; k < 4; k++)
            sq[k] = 32'(r2_frac[k]) * 32'(r2_frac[k]);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (i_adv) r3_v <= r2_v;
    end
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_tag   <= r2_tag;
            r3_seedh <= i_seed * gnf_pkg::H_MUL_SEED;
            for (int k = 0; k < 4; k++) begin
                r3_p[k]    <= {{16{r2_base[k][15]}}, r2_base[k]} * AXIS_MUL[k];
                r3_t2[k]   <= sq[k][31:16];
                r3_frac[k] <= r2_frac[k];
            end
        end
    end

    // Stage 4: corner hash sums, t cubed and the fade polynomial
    logic           r4_v;
    gnf_pkg::t_tag  r4_tag;
    logic [31:0]    r4_h [16];
    logic [15:0]    r4_t3 [4];
    logic [22:0]    r4_inner [4];
    logic [15:0]    r4_frac [4];
    logic [31:0]    hs [16];
    logic [31:0]    cu [4];

    always_comb begin
        for (int c = 0; c < 16; c++) begin
            hs[c] = r3_p[0] + r3_p[1] + r3_p[2] + r3_p[3] + r3_seedh;
            for (int k = 0; k < 4; k++)
                if (c[k]) hs[c] = hs[c] + AXIS_MUL[k];
        end
        for (int k = 0; k < 4; k++)
            cu[k] = 32'(r3_t2[k]) * 32'(r3_frac[k]);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (i_adv) r4_v <= r3_v;
    end
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r4_tag <= r3_tag;
            for (int c = 0; c < 16; c++) r4_h[c] <= hs[c];
            for (int k = 0; k < 4; k++) begin
                r4_t3[k]    <= cu[k][31:16];
                r4_inner[k] <= 23'd655360 - 23'(r3_frac[k]) * 23'd15
                             + 23'(r3_t2[k]) * 23'd6;
                r4_frac[k]  <= r3_frac[k];
            end
        end
    end

    // Stage 5: first hash mix, fade weight
    logic               r5_v;
    gnf_pkg::t_tag      r5_tag;
    logic [31:0]        r5_h [16];
    logic signed [23:0] r5_wt [4];
    logic [15:0]        r5_frac [4];
    logic signed [39:0] fp [4];

    always_comb begin
        for (int k = 0; k < 4; k++)
            fp[k] = 40'($signed({1'b0, r4_t3[k]})) * 40'($signed(r4_inner[k]));
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (i_adv) r5_v <= r4_v;
    end
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r5_tag <= r4_tag;
            for (int c = 0; c < 16; c++)
                r5_h[c] <= (r4_h[c] ^ (r4_h[c] >> 15)) * gnf_pkg::H_MIX_A;
            for (int k = 0; k < 4; k++) begin
                r5_wt[k]   <= fp[k][39:16];
                r5_frac[k] <= r4_frac[k];
            end
        end
    end

    // Stage 6: second hash mix
    logic               r6_v;
    gnf_pkg::t_tag      r6_tag;
    logic [31:0]        r6_h [16];
    logic signed [23:0] r6_wt [4];
    logic [15:0]        r6_frac [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else if (i_adv) r6_v <= r5_v;
    end
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r6_tag <= r5_tag;
            for (int c = 0; c < 16; c++)
                r6_h[c] <= (r5_h[c] ^ (r5_h[c] >> 13)) * gnf_pkg::H_MIX_B;
            for (int k = 0; k < 4; k++) begin
                r6_wt[k]   <= r5_wt[k];
                r6_frac[k] <= r5_frac[k];
            end
        end
    end

    // Stage 7: gradient pick and dot product for each corner
    logic               r7_v;
    gnf_pkg::t_tag      r7_tag;
    logic signed [23:0] r7_val [16];
    logic signed [23:0] r7_wt [4];
    logic [3:0][17:0]   dv [16];

    always_comb begin
        for (int c = 0; c < 16; c++)
            for (int k = 0; k < 4; k++)
                dv[c][k] = c[k] ? {2'b00, r6_frac[k]} - 18'h10000 : {2'b00, r6_frac[k]};
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else if (i_adv) r7_v <= r6_v;
    end
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r7_tag <= r6_tag;
            for (int c = 0; c < 16; c++)
                r7_val[c] <= corner_dot(r6_h[c][4:0] ^ r6_h[c][20:16], dv[c]);
            for (int k = 0; k < 4; k++) r7_wt[k] <= r6_wt[k];
        end
    end

    // Stage 8: blend along x
    logic               r8_v;
    gnf_pkg::t_tag      r8_tag;
    logic signed [23:0] r8_val [8];
    logic signed [23:0] r8_wt [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r8_v <= 1'b0;
        else if (i_adv) r8_v <= r7_v;
    end
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r8_tag <= r7_tag;
            for (int i = 0; i < 8; i++)
                r8_val[i] <= lerp(r7_val[2*i], r7_val[2*i+1], r7_wt[0]);
            for (int k = 0; k < 3; k++) r8_wt[k] <= r7_wt[k+1];
        end
    end

    // Stage 9: blend along y
    logic               r9_v;
    gnf_pkg::t_tag      r9_tag;
    logic signed [23:0] r9_val [4];
    logic signed [23:0] r9_wt [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r9_v <= 1'b0;
        else if (i_adv) r9_v <= r8_v;
    end
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r9_tag <= r8_tag;
            for (int i = 0; i < 4; i++)
                r9_val[i] <= lerp(r8_val[2*i], r8_val[2*i+1], r8_wt[0]);
            for (int k = 0; k < 2; k++) r9_wt[k] <= r8_wt[k+1];
        end
    end

    // Stage 10: blend along z
    logic               r10_v;
    gnf_pkg::t_tag      r10_tag;
    logic signed [23:0] r10_val [2];
    logic signed [23:0] r10_wt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r10_v <= 1'b0;
        else if (i_adv) r10_v <= r9_v;
    end
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r10_tag <= r9_tag;
            for (int i = 0; i < 2; i++)
                r10_val[i] <= lerp(r9_val[2*i], r9_val[2*i+1], r9_wt[0]);
            r10_wt <= r9_wt[1];
        end
    end

    // Stage 11: blend along w and scale by three quarters
    logic               r11_v;
    gnf_pkg::t_tag      r11_tag;
    logic signed [23:0] r11_val;
    logic signed [23:0] bw;
    logic signed [25:0] b3;

    always_comb begin
        bw = lerp(r10_val[0], r10_val[1], r10_wt);
        b3 = 26'(bw) * 26'sd3;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r11_v <= 1'b0;
        else if (i_adv) r11_v <= r10_v;
    end
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r11_tag <= r10_tag;
            r11_val <= b3[25:2];
        end
    end

    assign o_oct = '{r11_v, r11_tag, r11_val};

endmodule

[rtl/gnf_div.sv]
module gnf_div #(
    parameter int NW = 48,
    parameter int DW = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  logic                 i_neg,
    input  logic                 i_zero,
    input  logic [NW-1:0]        i_num,
    input  logic [DW-1:0]        i_den,
    output logic                 o_valid,
    output logic signed [15:0]   o_value
);

    localparam int QB = 18;

    logic          r_v    [QB+1];
    logic          r_neg  [QB+1];
    logic          r_zero [QB+1];
    logic          r_sat  [QB+1];
    logic [NW-1:0] r_rem  [QB+1];
    logic [DW-1:0] r_den  [QB+1];
    logic [QB-1:0] r_q    [QB+1];

    // Entry: flag a quotient that cannot fit the bit budget
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v[0] <= 1'b0;
        else if (i_adv) r_v[0] <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_neg[0]  <= i_neg;
            r_zero[0] <= i_zero;
            r_sat[0]  <= i_num >= (NW'(i_den) << QB);
            r_rem[0]  <= i_num;
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
        end
    end

    // One restoring step per stage, most significant quotient bit first
    for (genvar s = 1; s <= QB; s++) begin : g_step
        logic [NW-1:0] trial;
        logic          take;
        assign trial = NW'(r_den[s-1]) << (QB - s);
        assign take  = r_rem[s-1] >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[s] <= 1'b0;
            else if (i_adv) r_v[s] <= r_v[s-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_neg[s]  <= r_neg[s-1];
                r_zero[s] <= r_zero[s-1];
                r_sat[s]  <= r_sat[s-1];
                r_den[s]  <= r_den[s-1];
                r_rem[s]  <= take ? r_rem[s-1] - trial : r_rem[s-1];
                r_q[s]    <= r_q[s-1] | (QB'(take) << (QB - s));
            end
        end
    end

    // Apply the sign and clip to the output range
    always_comb begin
        if (r_zero[QB])
            o_value = 16'sd0;
        else if (r_neg[QB])
            o_value = (r_sat[QB] || r_q[QB] > QB'(32768)) ? -16'sd32768
                    : 16'(-$signed({1'b0, r_q[QB]}));
        else
            o_value = (r_sat[QB] || r_q[QB] > QB'(32767)) ? 16'sd32767
                    : 16'(r_q[QB]);
    end

    assign o_valid = r_v[QB];

endmodule

[rtl/gradient_noise_4d_fbm_top.sv]
// Channel  Direction  Ports                 Contents
// s_axis   in         i_s_axis_t*           point: coord_x..coord_w, 32 bits each
// m_axis   out        o_m_axis_t*           noise_value, 16 bits
// cfg      in         i_cfg_*, o_cfg_ready  register index and write data
//
// A point is issued as one job per octave, max(1, min(octave count,
// MAX_OCTAVES)) jobs, and the next point is accepted as the last one issues;
// the octave pipeline is fed one octave per cycle while it advances. After
// the last octave issues, the result passes 11 octave stages, 2 accumulate
// stages, 19 divider stages and the output register.
// Synchronous active-low reset clears all valid bits and loads the register
// defaults. A stalled output freezes the pipeline only when a result is
// ready to leave the last divider stage.
module gradient_noise_4d_fbm_top #(
    parameter int MAX_OCTAVES = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [127:0] i_s_axis_tdata,   // coord_x, coord_y, coord_z, coord_w
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [15:0]  o_m_axis_tdata,   // noise_value
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    localparam int OW     = $clog2(MAX_OCTAVES + 1);
    localparam int NORM_W = 19 + $clog2(MAX_OCTAVES);
    localparam int SUM_W  = 44 + $clog2(MAX_OCTAVES);

    // Configuration registers
    logic [31:0] r_seed;
    logic [3:0]  r_count;
    logic [23:0] r_base_freq;
    logic [23:0] r_lacunarity;
    logic [17:0] r_gain;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed       <= '0;
            r_count      <= 4'd1;
            r_base_freq  <= 24'd65536;
            r_lacunarity <= 24'd131072;
            r_gain       <= 18'd32768;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gnf_pkg::CFG_SEED:      r_seed       <= i_cfg_data;
                gnf_pkg::CFG_OCTAVES:   r_count      <= i_cfg_data[3:0];
                gnf_pkg::CFG_BASE_FREQ: r_base_freq  <= i_cfg_data[23:0];
                gnf_pkg::CFG_LACUNAR:   r_lacunarity <= i_cfg_data[23:0];
                gnf_pkg::CFG_GAIN:      r_gain       <= i_cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // Pipeline advance and output register
    logic               adv;
    logic               div_valid;
    logic signed [15:0] div_value;
    logic               r_out_valid;
    logic [15:0]        r_out_data;
    logic               out_load;

    assign adv      = !r_out_valid || i_m_axis_tready || !div_valid;
    assign out_load = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (out_load) r_out_valid <= div_valid;
    end
    always_ff @(posedge i_clk) begin
        if (out_load) r_out_data <= div_value;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Octave issue: hold the point, step frequency and amplitude
    logic             r_busy;
    logic [3:0][31:0] r_coord;
    logic [23:0]      r_freq;
    logic [17:0]      r_amp;
    logic [OW-1:0]    r_oct;
    logic [OW-1:0]    r_cnt;
    logic             issue_last;
    logic             accept;
    logic [47:0]      freq_prod;
    logic [35:0]      amp_prod;
    logic [23:0]      n_freq;
    logic [17:0]      n_amp;
    logic [OW-1:0]    cnt_clamp;

    assign issue_last      = (r_cnt == '0) || (r_oct == r_cnt - OW'(1));
    assign o_s_axis_tready = adv && (!r_busy || issue_last);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        freq_prod = 48'(r_freq) * 48'(r_lacunarity);
        n_freq    = (freq_prod[47:40] != '0) ? gnf_pkg::FREQ_MAX : freq_prod[39:16];
        amp_prod  = 36'(r_amp) * 36'(r_gain);
        n_amp     = (amp_prod[35:34] != '0) ? gnf_pkg::AMP_MAX : amp_prod[33:16];
        cnt_clamp = (32'(r_count) > 32'(MAX_OCTAVES)) ? OW'(MAX_OCTAVES) : OW'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_busy <= 1'b0;
        else if (adv) begin
            if (accept) r_busy <= 1'b1;
            else if (r_busy && issue_last) r_busy <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_coord <= i_s_axis_tdata;
            r_freq  <= r_base_freq;
            r_amp   <= gnf_pkg::AMP_ONE;
            r_oct   <= '0;
            r_cnt   <= cnt_clamp;
        end else if (adv && r_busy && !issue_last) begin
            r_freq <= n_freq;
            r_amp  <= n_amp;
            r_oct  <= r_oct + OW'(1);
        end
    end

    gnf_pkg::t_job job;
    gnf_pkg::t_oct oct;

    assign job = '{r_busy, r_oct == '0, issue_last, r_cnt == '0, r_amp, r_freq, r_coord};

    gnf_octave u_octave (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_seed  (r_seed),
        .i_job   (job),
        .o_oct   (oct)
    );

    // Weight each octave by its amplitude
    logic               r_p_v;
    gnf_pkg::t_tag      r_p_tag;
    logic signed [42:0] r_p_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p_v <= 1'b0;
        else if (adv) r_p_v <= oct.valid;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p_tag  <= oct.tag;
            r_p_prod <= 43'($signed({1'b0, oct.tag.amp})) * 43'(oct.value);
        end
    end

    // Accumulate weighted sum and amplitude sum over a point's octaves
    logic                    r_a_v;
    logic                    r_a_zero;
    logic signed [SUM_W-1:0] r_sum;
    logic [NORM_W-1:0]       r_norm;
    logic [SUM_W-1:0]        num_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_v <= 1'b0;
        else if (adv) r_a_v <= r_p_v && r_p_tag.last;
    end
    always_ff @(posedge i_clk) begin
        if (adv && r_p_v) begin
            r_a_zero <= r_p_tag.zero;
            if (r_p_tag.first) begin
                r_sum  <= SUM_W'(r_p_prod);
                r_norm <= NORM_W'(r_p_tag.amp);
            end else begin
                r_sum  <= r_sum + SUM_W'(r_p_prod);
                r_norm <= r_norm + NORM_W'(r_p_tag.amp);
            end
        end
    end

    assign num_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);

    gnf_div #(
        .NW (SUM_W),
        .DW (NORM_W + 1)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_a_v),
        .i_neg   (r_sum[SUM_W-1]),
        .i_zero  (r_a_zero),
        .i_num   (num_mag),
        .i_den   ({r_norm, 1'b0}),
        .o_valid (div_valid),
        .o_value (div_value)
    );

endmodule

[rtl/gnf_checker.sv]
module gnf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic        o_cfg_ready
);

    // A result waiting for transfer stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // A waiting result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // Reset empties the output register
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // Configuration is always taken
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> o_cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind gradient_noise_4d_fbm_top gnf_checker u_gnf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_cfg_ready     (o_cfg_ready)
);

[verif/gradient_noise_4d_fbm_top_test.sv]
module gradient_noise_4d_fbm_top_test;

    localparam int MAX_OCT   = 8;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1000;
    localparam int HOLD_LONG = 400;
    localparam int DRAIN     = 80;

    // Idling phases
    typedef enum int {PH_NONE, PH_SEND, PH_RECV, PH_BOTH} t_phase;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [127:0] i_s_axis_tdata = '0;   // coord_x, coord_y, coord_z, coord_w
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [15:0]  o_m_axis_tdata;        // noise_value
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [7:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;

    gradient_noise_4d_fbm_top #(.MAX_OCTAVES(MAX_OCT)) u_dut (.*);

    always #2 i_clk = ~i_clk;

    // Predictor copy of the registers
    logic [31:0] m_seed;
    logic [3:0]  m_octaves;
    logic [23:0] m_freq0;
    logic [23:0] m_lacun;
    logic [17:0] m_gain;

    logic [15:0] noise_due[$];
    int          n_errors = 0;
    int          idle_cycles = 0;
    t_phase      phase = PH_NONE;
    logic        hold_off = 1'b0;

    // Arithmetic shift right, floor rounding
    function automatic longint asr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic logic [31:0] lattice_hash(logic [31:0] c[4], logic [31:0] seed);
        logic [31:0] h;
        h = c[0] * gnf_pkg::H_MUL_X + c[1] * gnf_pkg::H_MUL_Y + c[2] * gnf_pkg::H_MUL_Z
            + c[3] * gnf_pkg::H_MUL_W + seed * gnf_pkg::H_MUL_SEED;
        h = h ^ (h >> 15);
        h = h * gnf_pkg::H_MIX_A;
        h = h ^ (h >> 13);
        h = h * gnf_pkg::H_MIX_B;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic longint quintic(longint t);
        longint t2, t3;
        t2 = (t * t) >>> 16;
        t3 = (t2 * t) >>> 16;
        return (t3 * (655360 - 15 * t + 6 * t2)) >>> 16;
    endfunction

    function automatic longint octave_noise(longint p[4], logic [23:0] f);
        logic [31:0] base[4];
        logic [31:0] lat[4];
        logic [31:0] hv;
        longint frac[4], wt[4], val[16], d[4], s, acc;
        logic [4:0] gi;
        int zax, b, n;
        for (int k = 0; k < 4; k++) begin
            s = asr(p[k] * longint'(f), 16);
            if (s > 64'sd2147483647) s = 64'sd2147483647;
            if (s < -64'sd2147483648) s = -64'sd2147483648;
            base[k] = 32'(asr(s, 16));
            frac[k] = s & 64'hFFFF;
            wt[k] = quintic(frac[k]);
        end
        for (int c = 0; c < 16; c++) begin
            for (int k = 0; k < 4; k++) begin
                lat[k] = base[k] + 32'((c >> k) & 1);
                d[k] = ((c >> k) & 1) ? frac[k] - 65536 : frac[k];
            end
            hv = lattice_hash(lat, m_seed);
            gi = hv[4:0];
            zax = gi[4:3];
            b = 2;
            acc = 0;
            for (int k = 0; k < 4; k++) begin
                if (k != zax) begin
                    acc = gi[b] ? acc - d[k] : acc + d[k];
                    if (b > 0) b--;
                end
            end
            val[c] = acc;
        end
        n = 16;
        for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < n / 2; i++)
                val[i] = val[2*i] + asr((val[2*i+1] - val[2*i]) * wt[k], 16);
            n /= 2;
        end
        return asr(val[0] * 3, 2);
    endfunction

    function automatic logic [15:0] fbm_noise(logic [127:0] pt);
        longint p[4];
        longint f, amp, sum, norm, q;
        int cnt;
        for (int k = 0; k < 4; k++) p[k] = longint'($signed(pt[32*k +: 32]));
        cnt = (m_octaves > MAX_OCT) ? MAX_OCT : m_octaves;
        f = m_freq0; amp = 65536; sum = 0; norm = 0; q = 0;
        for (int o = 0; o < cnt; o++) begin
            sum += amp * octave_noise(p, 24'(f));
            norm += amp;
            f = (f * m_lacun) >> 16;
            if (f > 64'hFFFFFF) f = 64'hFFFFFF;
            amp = (amp * m_gain) >> 16;
            if (amp > 64'h3FFFF) amp = 64'h3FFFF;
        end
        if (norm > 0) begin
            q = sum / (2 * norm);
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
        end
        return q[15:0];
    endfunction

    // Receiver: random stalls per phase, plus the long hold-off
    always @(posedge i_clk) begin
        int r;
        r = $urandom_range(99);
        if (hold_off) i_m_axis_tready <= 1'b0;
        else if (phase == PH_RECV) i_m_axis_tready <= (r >= 54);
        else if (phase == PH_BOTH) i_m_axis_tready <= (r >= 37);
        else i_m_axis_tready <= 1'b1;
    end

    // Check each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        logic [15:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (noise_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, o_m_axis_tdata);
                n_errors++;
            end else begin
                want = noise_due.pop_front();
                if (o_m_axis_tdata !== want) begin
                    $display("%0t: noise_value mismatch, expected %h, actual %h",
                             $time, want, o_m_axis_tdata);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer at all
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(logic [7:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            gnf_pkg::CFG_SEED:      m_seed    = data;
            gnf_pkg::CFG_OCTAVES:   m_octaves = data[3:0];
            gnf_pkg::CFG_BASE_FREQ: m_freq0   = data[23:0];
            gnf_pkg::CFG_LACUNAR:   m_lacun   = data[23:0];
            gnf_pkg::CFG_GAIN:      m_gain    = data[17:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Offer one point; optional typed expectation overrides the predictor
    task automatic send_point(logic [127:0] pt, bit fixed, logic [15:0] fixed_val);
        if (phase == PH_SEND || phase == PH_BOTH) begin
            while ($urandom_range(99) < (phase == PH_SEND ? 54 : 37)) begin
                i_s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= pt;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        noise_due.push_back(fixed ? fixed_val : fbm_noise(pt));
    endtask

    task automatic settle;
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (noise_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000000)) - 1000000);
            2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return $urandom_range(1) ? 32'h7FFFFFFF - $urandom_range(3)
                                                : 32'h80000000 + $urandom_range(3);
        endcase
    endfunction

    // Directed rows: point, whether the result is typed in, and its value
    typedef struct {
        logic [127:0] pt;
        bit           fixed;
        logic [15:0]  val;
    } t_row;

    t_row dir_rows[10] = '{
        '{128'h0, 1'b1, 16'h0000},   // lattice point: base corner distance and every fade weight are zero
        '{{32'h00010000, 32'h00020000, 32'hFFFF0000, 32'h00050000}, 1'b1, 16'h0000},
        '{{4{32'h7FFFFFFF}}, 1'b0, 16'h0},
        '{{4{32'h80000000}}, 1'b0, 16'h0},
        '{{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF}, 1'b0, 16'h0},
        '{{4{32'h0000FFFF}}, 1'b0, 16'h0},
        '{{4{32'hFFFF8000}}, 1'b0, 16'h0},
        '{{32'h00008000, 32'h00004000, 32'h0000C000, 32'h00002000}, 1'b0, 16'h0},
        '{{4{32'hFFFFFFFF}}, 1'b0, 16'h0},
        '{{32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'hF0F0F0F0}, 1'b0, 16'h0}
    };

    initial begin
        logic [127:0] pt;
        m_seed = 32'h0; m_octaves = 4'd1; m_freq0 = 24'h010000;
        m_lacun = 24'h020000; m_gain = 18'h08000;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults, directed rows
        foreach (dir_rows[i]) send_point(dir_rows[i].pt, dir_rows[i].fixed, dir_rows[i].val);
        settle();

        // Zero octaves give zero, out-of-range index is ignored
        write_reg(gnf_pkg::CFG_OCTAVES, 32'd0);
        write_reg(8'd7, 32'hFFFFFFFF);
        for (int i = 0; i < 3; i++) send_point(dir_rows[2 + i].pt, 1'b1, 16'h0000);
        settle();

        // Extremes: max seed, octave clamp, max frequency and lacunarity, gain 0x20000
        write_reg(gnf_pkg::CFG_SEED, 32'hFFFFFFFF);
        write_reg(gnf_pkg::CFG_OCTAVES, 32'd15);
        write_reg(gnf_pkg::CFG_BASE_FREQ, 32'hFFFFFF);
        write_reg(gnf_pkg::CFG_LACUNAR, 32'hFFFFFF);
        write_reg(gnf_pkg::CFG_GAIN, 32'h20000);
        for (int i = 2; i < $size(dir_rows); i++) send_point(dir_rows[i].pt, 1'b0, 16'h0);
        settle();
        write_reg(gnf_pkg::CFG_BASE_FREQ, 32'h0);
        write_reg(gnf_pkg::CFG_LACUNAR, 32'h0);
        write_reg(gnf_pkg::CFG_GAIN, 32'h0);
        for (int i = 2; i < 6; i++) send_point(dir_rows[i].pt, 1'b0, 16'h0);
        settle();

        // Random part: several settings, each under every idling phase
        for (int s = 0; s < 8; s++) begin
            write_reg(gnf_pkg::CFG_SEED, $urandom);
            write_reg(gnf_pkg::CFG_OCTAVES, (s == 0) ? 32'd8 : $urandom_range(9));
            write_reg(gnf_pkg::CFG_BASE_FREQ, $urandom_range(1) ? $urandom_range(24'h40000)
                                                                : $urandom_range(24'hFFFFFF));
            write_reg(gnf_pkg::CFG_LACUNAR, $urandom_range(1) ? $urandom_range(24'h30000)
                                                              : $urandom_range(24'hFFFFFF));
            write_reg(gnf_pkg::CFG_GAIN, $urandom_range(18'h20000));
            for (int ph = 0; ph < 4; ph++) begin
                phase = t_phase'(ph);
                // Long receiver hold-off while points keep coming
                if (s == 1 && ph == 0) begin
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (HOLD_LONG) @(posedge i_clk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
                for (int i = 0; i < N_RANDOM / 32; i++) begin
                    for (int k = 0; k < 4; k++) pt[32*k +: 32] = rand_coord();
                    send_point(pt, 1'b0, 16'h0);
                end
            end
            phase = PH_NONE;
            settle();
        end

        if (n_errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
